// ===== rtl/core/olid_pkg.sv =====
// Shared constants, codes and types of the ordered list core.
`timescale 1ns / 1ps
package olid_pkg;

   // Number of entries the list can hold, and widths that follow from it.
   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Fixed field widths of the request and result ports.
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 5;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 3;
   localparam int FOUND_W  = 4;
   localparam int COUNT_W  = 5;

   // Width wide enough to compare a position against the entry count.
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Request action codes.
   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd2;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_APPENDED = 3'd1,
      ST_FULL     = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_RANGE    = 3'd4,
      ST_NOTFOUND = 3'd5
   } olid_status_type;

   // Command broadcast from the controller to every cell of the chain.
   typedef struct packed {
      logic               ins_en;
      logic               del_en;
      logic [IDX_W-1:0]   ins_at;
      logic [CMP_W-1:0]   del_pos;
      logic [CNT_W-1:0]   count;
      logic [VALUE_W-1:0] value;
   } olid_bcast_type;

endpackage

// ===== rtl/core/olid_cell.sv =====
// One cell of the list chain: holds one entry, shifts with its neighbours and compares.
`timescale 1ns / 1ps
module olid_cell (
   input  logic                        clock,
   input  logic [olid_pkg::IDX_W-1:0]  cell_index,
   input  olid_pkg::olid_bcast_type    bcast,
   input  logic [olid_pkg::VALUE_W-1:0] left_entry,
   input  logic [olid_pkg::VALUE_W-1:0] right_entry,
   output logic [olid_pkg::VALUE_W-1:0] entry,
   output logic                        match
);

   logic [olid_pkg::VALUE_W-1:0] entry_ff;
   logic [olid_pkg::VALUE_W-1:0] entry_in;
   logic [olid_pkg::CNT_W-1:0]   index_cnt;
   logic                         live;
   logic                         take_new;
   logic                         take_left;
   logic                         take_right;

   assign index_cnt = olid_pkg::CNT_W'(cell_index);
   assign live      = index_cnt < bcast.count;

   // Decide how this cell moves for the current request.
   assign take_new   = bcast.ins_en && (cell_index == bcast.ins_at);
   assign take_left  = bcast.ins_en && (cell_index > bcast.ins_at)
                       && (index_cnt <= bcast.count);
   assign take_right = bcast.del_en
                       && (olid_pkg::CMP_W'(cell_index) >= bcast.del_pos)
                       && ((index_cnt + olid_pkg::CNT_W'(1)) < bcast.count);

   always_comb begin
      entry_in = entry_ff;
      if (take_new) begin
         entry_in = bcast.value;
      end else if (take_left) begin
         entry_in = left_entry;
      end else if (take_right) begin
         entry_in = right_entry;
      end
   end

   // Entry storage; its contents only matter once written.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // Search compare against the entry as it stood before this request.
   assign match = live && (entry_ff == bcast.value);
   assign entry = entry_ff;

endmodule

// ===== rtl/core/olid_first_match.sv =====
// Priority encoder that finds the lowest cell reporting a match.
`timescale 1ns / 1ps
module olid_first_match (
   input  logic [olid_pkg::CAPACITY-1:0] match_vec,
   output logic                          any_match,
   output logic [olid_pkg::IDX_W-1:0]    first_index
);

   // Scan from the top down so the lowest matching index wins.
   always_comb begin
      first_index = '0;
      for (int i = olid_pkg::CAPACITY - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            first_index = olid_pkg::IDX_W'(i);
         end
      end
   end

   assign any_match = |match_vec;

endmodule

// ===== rtl/core/ordered_list_insert_delete_search_core.sv =====
// Top level of the ordered list core: request decode, cell chain and result stage.
`timescale 1ns / 1ps
// The core keeps a bounded ordered list of signed 32-bit values in a chain of
// cells, one entry per cell. Each request is an insert, a delete or a search;
// all cells shift or compare together, so busy stays low: a new request may be
// issued on every clock. The result for a request appears on the rsp_ ports,
// marked by rsp_strobe, in the cycle after the request is accepted; it is shown
// for that one cycle only and cannot be held off, so the receiver must take it
// then. After reset the list is empty and no clearing pass is needed.
module ordered_list_insert_delete_search_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [olid_pkg::ACTION_W-1:0]       req_action,
   input  logic signed [olid_pkg::VALUE_W-1:0] req_item_value,
   input  logic [olid_pkg::POS_W-1:0]          req_position,
   output logic                                rsp_strobe,
   output logic [olid_pkg::STATUS_W-1:0]       rsp_status,
   output logic [olid_pkg::FOUND_W-1:0]        rsp_found_index,
   output logic [olid_pkg::COUNT_W-1:0]        rsp_entry_count
);

   logic                             accept;
   logic [olid_pkg::CNT_W-1:0]       used_count_ff;
   logic [olid_pkg::CNT_W-1:0]       used_count_in;
   logic [olid_pkg::CMP_W-1:0]       pos_cmp;
   logic [olid_pkg::CMP_W-1:0]       count_cmp;
   olid_pkg::olid_bcast_type         bcast;
   olid_pkg::olid_status_type        status_in;
   logic [olid_pkg::CAPACITY-1:0]    match_vec;
   logic [olid_pkg::VALUE_W-1:0]     entries [olid_pkg::CAPACITY];

   // Result stage registers.
   logic                             rsp_valid_ff;
   olid_pkg::olid_status_type        rsp_status_ff;
   logic                             rsp_search_ff;
   logic [olid_pkg::CAPACITY-1:0]    rsp_match_ff;
   logic [olid_pkg::CNT_W-1:0]       rsp_count_ff;
   logic                             any_match;
   logic [olid_pkg::IDX_W-1:0]       first_index;
   olid_pkg::olid_status_type        final_status;

   // The core never stalls; busy is tied low.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign pos_cmp   = olid_pkg::CMP_W'(req_position);
   assign count_cmp = olid_pkg::CMP_W'(used_count_ff);

   // Decode the request into a command for the chain and a status.
   always_comb begin
      bcast         = '0;
      bcast.count   = used_count_ff;
      bcast.value   = req_item_value;
      bcast.del_pos = pos_cmp;
      status_in     = olid_pkg::ST_OK;
      used_count_in = used_count_ff;
      case (req_action)
         olid_pkg::ACT_INSERT: begin
            if (used_count_ff >= olid_pkg::CNT_W'(olid_pkg::CAPACITY)) begin
               status_in = olid_pkg::ST_FULL;
            end else begin
               bcast.ins_en  = accept;
               used_count_in = used_count_ff + olid_pkg::CNT_W'(1);
               if ((used_count_ff == '0) || (req_position == '0)) begin
                  bcast.ins_at = '0;
               end else if (pos_cmp > count_cmp) begin
                  bcast.ins_at = olid_pkg::IDX_W'(used_count_ff);
                  status_in    = olid_pkg::ST_APPENDED;
               end else begin
                  bcast.ins_at = olid_pkg::IDX_W'(req_position);
               end
            end
         end
         olid_pkg::ACT_DELETE: begin
            if (used_count_ff == '0) begin
               status_in = olid_pkg::ST_EMPTY;
            end else if (pos_cmp >= count_cmp) begin
               status_in = olid_pkg::ST_RANGE;
            end else begin
               bcast.del_en  = accept;
               used_count_in = used_count_ff - olid_pkg::CNT_W'(1);
            end
         end
         olid_pkg::ACT_SEARCH: begin
            if (used_count_ff == '0) begin
               status_in = olid_pkg::ST_EMPTY;
            end
         end
         default: begin
            status_in = olid_pkg::ST_OK;
         end
      endcase
   end

   // The chain of cells; the ends see a zero neighbour that is never taken.
   for (genvar g = 0; g < olid_pkg::CAPACITY; g++) begin : g_cell
      logic [olid_pkg::VALUE_W-1:0] left_entry;
      logic [olid_pkg::VALUE_W-1:0] right_entry;

      if (g == 0) begin : g_first
         assign left_entry = '0;
      end else begin : g_inner_l
         assign left_entry = entries[g-1];
      end

      if (g == olid_pkg::CAPACITY - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_inner_r
         assign right_entry = entries[g+1];
      end

      olid_cell u_cell (
         .clock       (clock),
         .cell_index  (olid_pkg::IDX_W'(g)),
         .bcast       (bcast),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entries[g]),
         .match       (match_vec[g])
      );
   end

   // Entry count and result stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            used_count_ff <= used_count_in;
         end
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= status_in;
         rsp_search_ff <= (req_action == olid_pkg::ACT_SEARCH);
         rsp_match_ff  <= match_vec;
         rsp_count_ff  <= used_count_in;
      end
   end

   olid_first_match u_first_match (
      .match_vec   (rsp_match_ff),
      .any_match   (any_match),
      .first_index (first_index)
   );

   // A search over a non-empty list with no match is reported as not found.
   always_comb begin
      final_status = rsp_status_ff;
      if (rsp_search_ff && (rsp_status_ff == olid_pkg::ST_OK) && !any_match) begin
         final_status = olid_pkg::ST_NOTFOUND;
      end
   end

   assign rsp_strobe      = rsp_valid_ff;
   assign rsp_status      = final_status;
   assign rsp_found_index = (rsp_search_ff && (final_status == olid_pkg::ST_OK))
                            ? olid_pkg::FOUND_W'(first_index) : '0;
   assign rsp_entry_count = olid_pkg::COUNT_W'(rsp_count_ff);

   // The entry count never exceeds the capacity.
   assert property (@(posedge clock) disable iff (reset)
      used_count_ff <= olid_pkg::CNT_W'(olid_pkg::CAPACITY))
      else $error("entry count above capacity");

   // Each accepted request gives exactly one result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("result missing after accepted request");

   // The reported count is the count the list holds after the request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_count_ff == used_count_ff))
      else $error("reported count differs from list count");

   // A successful search points at a cell that did match.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_search_ff && (final_status == olid_pkg::ST_OK))
      |-> rsp_match_ff[first_index])
      else $error("found index does not match");

endmodule
